[rtl/core/durm_pkg.sv]
// Package for the dual ultrasonic ranger with per-sensor median filter.
// Holds sizes, register codes, reset values and the cell control types.
// No dependencies.
package durm_pkg;

    localparam int WINDOW_MAX = 16;
    localparam int IDX_W      = $clog2(WINDOW_MAX);
    localparam int CNT_W      = $clog2(WINDOW_MAX + 1);
    localparam int WIN_CFG_W  = 5;
    localparam int RANGE_W    = 16;
    localparam int TIME_W     = 32;
    localparam int SCALE_W    = 16;
    localparam int PROD_W     = TIME_W + SCALE_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [WIN_CFG_W-1:0] WINDOW_RST = WIN_CFG_W'(5);
    localparam logic [SCALE_W-1:0]   SCALE_RST  = SCALE_W'(11239);
    localparam logic [PROD_W-1:0]    ROUND_HALF = PROD_W'(32768);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW  = 2'd0,
        CFG_SCALE   = 2'd1,
        CFG_BACKEND = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic push;
        logic load;
        logic rank;
    } t_cell_ctl;

    typedef struct packed {
        logic [RANGE_W-1:0] data;
        logic [IDX_W-1:0]   idx;
        logic               vld;
    } t_probe;

endpackage

[rtl/core/durm_in_if.sv]
// Echo capture channel: valid/ready handshake and one capture word.
// Depends on durm_pkg.
interface durm_in_if import durm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              rise_seen;
    logic              fall_seen;
    logic [TIME_W-1:0] rise_time_us;
    logic [TIME_W-1:0] fall_time_us;

    modport source (output valid, rise_seen, fall_seen, rise_time_us, fall_time_us,
                    input ready);
    modport sink   (input valid, rise_seen, fall_seen, rise_time_us, fall_time_us,
                    output ready);
endinterface

[rtl/core/durm_out_if.sv]
// Range result channel: valid/ready handshake and one range word.
// Depends on durm_pkg.
interface durm_out_if import durm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               sensor_side;
    logic               range_valid;
    logic [RANGE_W-1:0] range_mm;
    logic [CNT_W-1:0]   sample_count;

    modport source (output valid, sensor_side, range_valid, range_mm, sample_count,
                    input ready);
    modport sink   (input valid, sensor_side, range_valid, range_mm, sample_count,
                    output ready);
endinterface

[rtl/core/durm_cell.sv]
// One history cell: holds a sample, passes a probe round the ring and
// accumulates the rank of its own sample. Depends on durm_pkg.
module durm_cell import durm_pkg::*; (
    input  logic               i_clk,
    input  t_cell_ctl          i_ctl,
    input  logic [IDX_W-1:0]   i_idx,
    input  logic               i_kvld,
    input  logic [RANGE_W-1:0] i_key,
    input  t_probe             i_probe,
    output logic [RANGE_W-1:0] o_key,
    output t_probe             o_probe,
    output logic [IDX_W-1:0]   o_rank
);

    logic [RANGE_W-1:0] r_key, n_key;
    t_probe             r_probe, n_probe;
    logic [IDX_W-1:0]   r_rank, n_rank;
    logic               w_below;

    assign w_below = r_probe.vld &&
                     ((r_probe.data < r_key) ||
                      ((r_probe.data == r_key) && (r_probe.idx < i_idx)));

    always_comb begin
        n_key   = r_key;
        n_probe = r_probe;
        n_rank  = r_rank;
        if (i_ctl.push) begin
            n_key = i_key;
        end
        if (i_ctl.load) begin
            n_probe = '{data: r_key, idx: i_idx, vld: i_kvld};
            n_rank  = '0;
        end else if (i_ctl.rank) begin
            n_probe = i_probe;
            if (w_below) begin
                n_rank = r_rank + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_probe <= n_probe;
        r_rank  <= n_rank;
    end

    assign o_key   = r_key;
    assign o_probe = r_probe;
    assign o_rank  = r_rank;

endmodule

[rtl/core/durm_chain.sv]
// History of one sensor: a row of cells with a shift line for samples and a
// probe ring for ranking, plus the fill count. Depends on durm_pkg, durm_cell.
module durm_chain import durm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cell_ctl          i_ctl,
    input  logic [CNT_W-1:0]   i_window,
    input  logic [RANGE_W-1:0] i_sample,
    output logic [CNT_W-1:0]   o_count,
    output logic [RANGE_W-1:0] o_median
);

    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W:0]     w_inc;
    logic [IDX_W-1:0]   w_target;
    logic [RANGE_W-1:0] w_key   [WINDOW_MAX];
    t_probe             w_probe [WINDOW_MAX];
    logic [IDX_W-1:0]   w_rank  [WINDOW_MAX];
    logic               w_kvld  [WINDOW_MAX];

    for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_cell
        assign w_kvld[k] = (k < int'(r_count));

        durm_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (i_ctl),
            .i_idx   (IDX_W'(k)),
            .i_kvld  (w_kvld[k]),
            .i_key   ((k == 0) ? i_sample : w_key[(k + WINDOW_MAX - 1) % WINDOW_MAX]),
            .i_probe (w_probe[(k + WINDOW_MAX - 1) % WINDOW_MAX]),
            .o_key   (w_key[k]),
            .o_probe (w_probe[k]),
            .o_rank  (w_rank[k])
        );
    end

    always_comb begin
        w_inc   = {1'b0, r_count} + 1'b1;
        n_count = r_count;
        if (i_ctl.push) begin
            if (w_inc > {1'b0, i_window}) begin
                n_count = i_window;
            end else begin
                n_count = CNT_W'(w_inc);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign w_target = IDX_W'(r_count >> 1);

    always_comb begin
        o_median = '0;
        for (int k = 0; k < WINDOW_MAX; k++) begin
            if (w_kvld[k] && (w_rank[k] == w_target)) begin
                o_median = o_median | w_key[k];
            end
        end
    end

    assign o_count = r_count;

endmodule

[rtl/core/dual_ultrasonic_ranger_median.sv]
// Top level: two-sensor echo ranger with a sliding upper-median filter.
// Depends on durm_pkg, durm_in_if, durm_out_if, durm_chain.
//
//   channel   direction  word
//   i_echo    in         rise_seen, fall_seen, rise_time_us, fall_time_us
//   o_range   out        sensor_side, range_valid, range_mm, sample_count
//   i_cfg_*   in         write enable, register index, write data
//
// A valid echo runs from acceptance through the multiply, push and load
// states and the rank pass round the cell ring; an invalid echo goes
// straight to the result state. One word is worked on at a time.
// Reset is synchronous; the histories hold no reset value and are read only
// below the fill count. A stalled result holds the block in its last state.
module dual_ultrasonic_ranger_median import durm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    durm_in_if.sink               i_echo,
    durm_out_if.source            o_range,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_PUSH,
        S_LOAD,
        S_RANK,
        S_DONE
    } t_state;

    t_state             r_state;
    logic [IDX_W-1:0]   r_step;
    logic               r_left_turn;
    logic               r_side;
    logic               r_valid;
    logic [TIME_W-1:0]  r_pulse;
    logic [PROD_W-1:0]  r_prod;

    logic [WIN_CFG_W-1:0] r_window;
    logic [SCALE_W-1:0]   r_scale;
    logic                 r_backend;

    logic               r_out_vld;
    logic               r_out_side;
    logic               r_out_rvalid;
    logic [RANGE_W-1:0] r_out_range;
    logic [CNT_W-1:0]   r_out_count;

    logic                      w_in_acc;
    logic                      w_out_load;
    logic                      w_echo_ok;
    logic [CNT_W-1:0]          w_window;
    logic [PROD_W-1:0]         w_round;
    logic [PROD_W-RANGE_W-1:0] w_mm;
    logic [RANGE_W-1:0]        w_sample;
    t_cell_ctl                 w_ctl;
    t_cell_ctl                 w_ctl_l;
    t_cell_ctl                 w_ctl_r;
    logic [CNT_W-1:0]          w_count_l, w_count_r;
    logic [RANGE_W-1:0]        w_med_l, w_med_r;

    assign i_echo.ready = (r_state == S_IDLE);
    assign w_in_acc     = i_echo.valid && i_echo.ready;
    assign w_out_load   = (r_state == S_DONE) && (!r_out_vld || o_range.ready);

    assign w_echo_ok = r_backend && i_echo.rise_seen && i_echo.fall_seen &&
                       (i_echo.fall_time_us > i_echo.rise_time_us);

    always_comb begin
        if (r_window == '0) begin
            w_window = CNT_W'(1);
        end else if (int'(r_window) > WINDOW_MAX) begin
            w_window = CNT_W'(WINDOW_MAX);
        end else begin
            w_window = CNT_W'(r_window);
        end
    end

    assign w_round  = r_prod + ROUND_HALF;
    assign w_mm     = w_round[PROD_W-1:RANGE_W];
    assign w_sample = (|w_mm[PROD_W-RANGE_W-1:RANGE_W]) ? '1 : w_mm[RANGE_W-1:0];

    assign w_ctl   = '{push: (r_state == S_PUSH),
                       load: (r_state == S_LOAD),
                       rank: (r_state == S_RANK)};
    assign w_ctl_l = r_side ? '0 : w_ctl;
    assign w_ctl_r = r_side ? w_ctl : '0;

    durm_chain u_chain_l (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl_l),
        .i_window (w_window),
        .i_sample (w_sample),
        .o_count  (w_count_l),
        .o_median (w_med_l)
    );

    durm_chain u_chain_r (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl_r),
        .i_window (w_window),
        .i_sample (w_sample),
        .o_count  (w_count_r),
        .o_median (w_med_r)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window  <= WINDOW_RST;
            r_scale   <= SCALE_RST;
            r_backend <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WINDOW:  r_window  <= i_cfg_data[WIN_CFG_W-1:0];
                CFG_SCALE:   r_scale   <= i_cfg_data[SCALE_W-1:0];
                CFG_BACKEND: r_backend <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_left_turn <= 1'b1;
            r_out_vld   <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_vld <= 1'b1;
            end else if (o_range.ready) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_left_turn <= !r_left_turn;
                        r_state     <= w_echo_ok ? S_MUL : S_DONE;
                    end
                end
                S_MUL:  r_state <= S_PUSH;
                S_PUSH: r_state <= S_LOAD;
                S_LOAD: begin
                    r_step  <= '0;
                    r_state <= S_RANK;
                end
                S_RANK: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == IDX_W'(WINDOW_MAX - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_side  <= !r_left_turn;
            r_valid <= w_echo_ok;
            r_pulse <= i_echo.fall_time_us - i_echo.rise_time_us;
        end
        if (r_state == S_MUL) begin
            r_prod <= PROD_W'(r_pulse) * PROD_W'(r_scale);
        end
        if (w_out_load) begin
            r_out_side   <= r_side;
            r_out_rvalid <= r_valid;
            r_out_range  <= r_valid ? (r_side ? w_med_r : w_med_l) : '0;
            r_out_count  <= r_side ? w_count_r : w_count_l;
        end
    end

    assign o_range.valid        = r_out_vld;
    assign o_range.sensor_side  = r_out_side;
    assign o_range.range_valid  = r_out_rvalid;
    assign o_range.range_mm     = r_out_range;
    assign o_range.sample_count = r_out_count;

endmodule

[rtl/core/durm_chk.sv]
// Port-level checks for the ranger, attached to the top level by bind.
// Depends on durm_pkg and dual_ultrasonic_ranger_median.
module durm_chk import durm_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic               i_side,
    input logic               i_rvalid,
    input logic [RANGE_W-1:0] i_range,
    input logic [CNT_W-1:0]   i_count
);

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_rvalid) |-> (i_range == '0))
        else $error("invalid range word carries a non-zero distance");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("capture word taken while another is in work");

    a_valid_has_samples: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_rvalid) |-> (i_count != '0))
        else $error("valid range with an empty history");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable({i_side, i_rvalid, i_range, i_count})))
        else $error("stalled range word changed");

endmodule

bind dual_ultrasonic_ranger_median durm_chk u_durm_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_echo.valid),
    .i_in_ready  (i_echo.ready),
    .i_out_valid (o_range.valid),
    .i_out_ready (o_range.ready),
    .i_side      (o_range.sensor_side),
    .i_rvalid    (o_range.range_valid),
    .i_range     (o_range.range_mm),
    .i_count     (o_range.sample_count)
);
